@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: operation and error
// codes, controller states and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int KIND_WIDTH         = 3;
   localparam int ERR_WIDTH          = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } kind_type;

   typedef enum logic [ERR_WIDTH-1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

endpackage

`default_nettype wire

@@ rtl/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the double-ended queue: the request channel that
// carries one operation and the response channel that carries its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if
   import deq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [KIND_WIDTH-1:0] kind;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
#(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(DEPTH_DEFAULT + 1)
);
   logic                   valid;
   logic                   ready;
   logic [DATA_WIDTH-1:0]  front_value;
   logic [DATA_WIDTH-1:0]  back_value;
   logic [COUNT_WIDTH-1:0] count;
   logic                   is_empty;
   logic [ERR_WIDTH-1:0]   error;

   modport source (output valid, output front_value, output back_value, output count,
                   output is_empty, output error, input ready);
   modport sink   (input valid, input front_value, input back_value, input count,
                   input is_empty, input error, output ready);
endinterface

`default_nettype wire

@@ rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Element storage: simple dual-port synchronous memory, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int ADDR_WIDTH = $clog2(DEPTH_DEFAULT)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue kept as a circular buffer in one memory.
// ----------------------------------------------------------------------------
// Each request transaction carries one operation (push back, push front, pop
// front, pop back or query) and yields exactly one response transaction with
// the front and back elements, the count, an empty flag and an error code as
// they stand after the operation. Front and back elements are held in
// registers next to the memory; a pop that leaves two or more elements passes
// through the read state, since the new end element is read from the memory
// through its registered read port. A new request is taken while the
// previous response is being accepted. Pushing to a full queue or
// popping an empty one changes nothing and reports an error; an empty queue
// reports zero front and back values. Codes 5 to 7 of kind act as a query.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   deq_req_if.sink    req_if,
   deq_rsp_if.source  rsp_if
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
   localparam logic [CW:0]   WRAP       = (CW + 1)'(DEPTH);

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(offset);
      if (sum >= WRAP) begin
         sum = sum - WRAP;
      end
      return AW'(sum);
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic                  read_front_ff, read_front_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_front_ff, rsp_front_in;
   logic [DATA_WIDTH-1:0] rsp_back_ff, rsp_back_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   err_type               rsp_err_ff, rsp_err_in;

   logic                  accept;
   logic                  empty;
   logic                  full;
   err_type               err;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   deq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == FULL_COUNT);
   assign accept = req_if.valid && req_if.ready;

   // operation decode and index update
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      read_front_in = read_front_ff;
      err           = ERR_OK;
      wr_en         = 1'b0;
      wr_addr       = wrap_add(head_ff, count_ff);
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      unique case (req_if.kind)
         OP_PUSH_BACK: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               back_in  = req_if.value;
               if (empty) begin
                  front_in = req_if.value;
               end
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               err = ERR_FULL;
            end else begin
               head_in  = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
               wr_en    = 1'b1;
               wr_addr  = head_in;
               count_in = count_ff + 1'b1;
               front_in = req_if.value;
               if (empty) begin
                  back_in = req_if.value;
               end
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               err = ERR_EMPTY;
            end else begin
               head_in  = wrap_add(head_ff, CW'(1));
               count_in = count_ff - 1'b1;
               if (count_ff == CW'(2)) begin
                  front_in = back_ff;
               end else if (count_ff > CW'(2)) begin
                  rd_en         = 1'b1;
                  rd_addr       = head_in;
                  read_front_in = 1'b1;
               end
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               err = ERR_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               if (count_ff == CW'(2)) begin
                  back_in = front_ff;
               end else if (count_ff > CW'(2)) begin
                  rd_en         = 1'b1;
                  rd_addr       = wrap_add(head_ff, count_ff - CW'(2));
                  read_front_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         head_in       = head_ff;
         count_in      = count_ff;
         front_in      = front_ff;
         back_in       = back_ff;
         read_front_in = read_front_ff;
         wr_en         = 1'b0;
         rd_en         = 1'b0;
      end
   end

   // controller and response register
   always_comb begin
      state_in     = state_ff;
      req_if.ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_front_in = rsp_front_ff;
      rsp_back_in  = rsp_back_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = !rsp_valid_ff || rsp_if.ready;
            if (accept) begin
               if (rd_en) begin
                  state_in     = S_READ;
                  rsp_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_front_in = (count_in == '0) ? '0 : front_in;
                  rsp_back_in  = (count_in == '0) ? '0 : back_in;
                  rsp_count_in = count_in;
                  rsp_empty_in = (count_in == '0);
                  rsp_err_in   = err;
               end
            end
         end
         S_READ: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_front_in = read_front_ff ? rd_data : front_ff;
            rsp_back_in  = read_front_ff ? back_ff : rd_data;
            rsp_count_in = count_ff;
            rsp_empty_in = 1'b0;
            rsp_err_in   = ERR_OK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // element registers; the end fetched from memory lands here
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         if (read_front_ff) begin
            front_ff <= rd_data;
         end else begin
            back_ff <= rd_data;
         end
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
      end
      read_front_ff <= read_front_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.front_value = rsp_front_ff;
   assign rsp_if.back_value  = rsp_back_ff;
   assign rsp_if.count       = rsp_count_ff;
   assign rsp_if.is_empty    = rsp_empty_ff;
   assign rsp_if.error       = rsp_err_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.is_empty |-> rsp_if.front_value == '0 && rsp_if.back_value == '0)
      else $error("empty queue reports nonzero values");

   a_read_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> $past(accept) && ($past(req_if.kind) == OP_POP_FRONT ||
                                               $past(req_if.kind) == OP_POP_BACK))
      else $error("memory fetch without a pop");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while response stalled");

   a_read_closes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("fetch did not produce a response");

endmodule

`default_nettype wire

@@ tb/tb_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking testbench of the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A driver and a monitor run as clocked processes around the block. The driver
// takes operations from a list built at time zero: a directed opening on the
// empty and nearly empty queue, one fill to full and drain to empty, then
// random mixes. Every accepted request transaction goes through a shadow deque
// that predicts the response, and every response transaction is checked field
// by field against the oldest prediction. Both sides idle at random, the
// receiver also holds off for a long stretch, and the sender pauses twice until
// the queue side has caught up.
// ----------------------------------------------------------------------------

module tb_double_ended_queue;
   import deq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int DATA_W         = DATA_WIDTH_DEFAULT;
   localparam int COUNT_W        = $clog2(DEPTH + 1);
   localparam int PTR_W          = $clog2(DEPTH);
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_GAP        = 14;
   localparam int MAX_REPORTS    = 10;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;
   localparam int MIX_SEGMENTS   = 15;
   localparam int SEGMENT_LEN    = 32;

   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_LO  = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_MID = 3'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED_HI  = 3'd7;

   typedef struct {
      logic [KIND_WIDTH-1:0] kind;
      logic [DATA_W-1:0]     value;
      int unsigned           gap;
      bit                    drain;
   } deq_op_type;

   typedef struct {
      logic [DATA_W-1:0]    front_value;
      logic [DATA_W-1:0]    back_value;
      logic [COUNT_W-1:0]   count;
      logic                 is_empty;
      logic [ERR_WIDTH-1:0] error;
   } deq_result_type;

   logic clock = 1'b0;
   logic reset;

   deq_req_if #(.DATA_WIDTH(DATA_W)) req_ch ();
   deq_rsp_if #(.DATA_WIDTH(DATA_W), .COUNT_WIDTH(COUNT_W)) rsp_ch ();

   double_ended_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   deq_op_type     pending_ops[$];
   deq_result_type expected_results[$];

   // shadow deque
   logic [DATA_W-1:0]  shadow_store [DEPTH];
   logic [PTR_W-1:0]   shadow_head  = '0;
   logic [COUNT_W-1:0] shadow_count = '0;

   int unsigned accepted_items  = 0;
   int unsigned total_items     = 0;
   int unsigned checked_results = 0;
   int unsigned mismatches      = 0;
   int unsigned push_total      = 0;
   int unsigned pop_total       = 0;
   int unsigned query_total     = 0;
   int unsigned full_errors     = 0;
   int unsigned empty_errors    = 0;
   int unsigned peak_count      = 0;
   int unsigned gen_count       = 0;
   int unsigned gap_left        = 0;
   int unsigned stall_left      = 0;
   int unsigned idle_cycles     = 0;
   bit          req_sent        = 1'b0;
   bit          rsp_taken       = 1'b0;
   bit          rsp_hold        = 1'b0;
   bit          sender_quiet    = 1'b0;

   task automatic apply_operation(input logic [KIND_WIDTH-1:0] kind,
                                  input logic [DATA_W-1:0] value,
                                  output deq_result_type res);
      logic [PTR_W-1:0] tail_slot;
      res.error = ERR_OK;
      case (kind)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            push_total++;
            if (shadow_count == DEPTH) begin
               res.error = ERR_FULL;
               full_errors++;
            end else if (kind == OP_PUSH_BACK) begin
               tail_slot = shadow_head + shadow_count[PTR_W-1:0];
               shadow_store[tail_slot] = value;
               shadow_count++;
            end else begin
               shadow_head = shadow_head - 1'b1;
               shadow_store[shadow_head] = value;
               shadow_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            pop_total++;
            if (shadow_count == 0) begin
               res.error = ERR_EMPTY;
               empty_errors++;
            end else begin
               if (kind == OP_POP_FRONT) shadow_head = shadow_head + 1'b1;
               shadow_count--;
            end
         end
         default: begin
            query_total++;
         end
      endcase
      if (shadow_count > peak_count) peak_count = shadow_count;
      res.front_value = '0;
      res.back_value  = '0;
      if (shadow_count != 0) begin
         tail_slot = shadow_head + shadow_count[PTR_W-1:0] - 1'b1;
         res.front_value = shadow_store[shadow_head];
         res.back_value  = shadow_store[tail_slot];
      end
      res.count    = shadow_count;
      res.is_empty = (shadow_count == 0);
   endtask

   function automatic logic [DATA_W-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return DATA_W'($urandom());
   endfunction

   function automatic logic [KIND_WIDTH-1:0] random_push();
      return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
   endfunction

   function automatic logic [KIND_WIDTH-1:0] random_pop();
      return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   task automatic add_item(input logic [KIND_WIDTH-1:0] kind,
                           input logic [DATA_W-1:0] value, input bit drain);
      deq_op_type op;
      op.kind  = kind;
      op.value = value;
      op.gap   = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
      op.drain = drain;
      pending_ops = {pending_ops, op};
      total_items++;
      case (kind)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (gen_count < DEPTH) gen_count++;
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (gen_count > 0) gen_count--;
         end
         default: ;
      endcase
   endtask

   task automatic build_directed();
      add_item(OP_QUERY, 32'h1234_5678, 1'b0);
      add_item(OP_POP_FRONT, '0, 1'b0);
      add_item(OP_POP_BACK, '1, 1'b0);
      add_item(KIND_UNUSED_LO, 32'hFFFF_0000, 1'b0);
      add_item(OP_PUSH_FRONT, '0, 1'b0);
      add_item(OP_PUSH_BACK, '1, 1'b0);
      add_item(OP_PUSH_FRONT, 32'h0000_0001, 1'b0);
      add_item(OP_PUSH_BACK, 32'h8000_0000, 1'b0);
      add_item(OP_PUSH_BACK, 32'hA5A5_A5A5, 1'b0);
      add_item(OP_POP_FRONT, '1, 1'b0);
      add_item(OP_POP_BACK, '0, 1'b0);
      add_item(KIND_UNUSED_MID, 32'h5A5A_5A5A, 1'b0);
      add_item(KIND_UNUSED_HI, '1, 1'b0);
      add_item(OP_POP_BACK, '0, 1'b0);
      add_item(OP_POP_FRONT, '0, 1'b0);
      add_item(OP_POP_FRONT, '0, 1'b0);
      add_item(OP_POP_BACK, '0, 1'b0);
      add_item(OP_PUSH_BACK, 32'hDEAD_BEEF, 1'b0);
      add_item(OP_POP_BACK, '0, 1'b0);
      add_item(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
      add_item(OP_QUERY, '0, 1'b0);
      add_item(OP_POP_FRONT, '0, 1'b0);
   endtask

   task automatic build_random();
      int unsigned pick;
      int unsigned push_share;
      bit          first;
      // fill to full, push past full, drain to empty, pop past empty
      sender_quiet = 1'b0;
      first = 1'b1;
      while (gen_count < DEPTH) begin
         add_item(random_push(), random_value(), first);
         first = 1'b0;
      end
      repeat (3) add_item(random_push(), random_value(), 1'b0);
      add_item(OP_QUERY, random_value(), 1'b0);
      while (gen_count > 0) add_item(random_pop(), random_value(), 1'b0);
      repeat (2) add_item(random_pop(), random_value(), 1'b0);
      // random mixes, push-heavy or pop-heavy per segment
      first = 1'b1;
      repeat (MIX_SEGMENTS) begin
         sender_quiet = ($urandom_range(0, 3) == 0);
         push_share = $urandom_range(20, 80);
         repeat (SEGMENT_LEN) begin
            pick = $urandom_range(0, 99);
            if (pick < push_share)
               add_item(random_push(), random_value(), first);
            else if (pick < 96)
               add_item(random_pop(), random_value(), first);
            else if (pick < 98)
               add_item(OP_QUERY, random_value(), first);
            else
               add_item(KIND_WIDTH'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                        random_value(), first);
            first = 1'b0;
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin : sender
      deq_op_type op;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_sent) begin
         req_sent = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_ops.size() == 0 ||
                      (pending_ops[0].drain && expected_results.size() != 0)) begin
            req_ch.valid <= 1'b0;
         end else begin
            op = pending_ops[0];
            pending_ops.delete(0);
            req_ch.valid <= 1'b1;
            req_ch.kind  <= op.kind;
            req_ch.value <= op.value;
            gap_left = op.gap;
         end
      end
   end

   // response ready, with stretches of no stalling
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            stall_left = (((checked_results / 97) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !rsp_hold;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin : receiver_hold
      while (accepted_items < HOLD_AT) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // monitor: check responses, then predict accepted requests
   always @(posedge clock) begin : monitor
      deq_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_taken = 1'b1;
         checked_results++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] response transaction with nothing pending: front=%h back=%h",
                        $realtime, rsp_ch.front_value, rsp_ch.back_value);
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (rsp_ch.front_value !== want.front_value ||
                rsp_ch.back_value  !== want.back_value  ||
                rsp_ch.count       !== want.count       ||
                rsp_ch.is_empty    !== want.is_empty    ||
                rsp_ch.error       !== want.error) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("[%0t] mismatch on response %0d", $realtime, checked_results);
                  $display("   expected front=%h back=%h count=%0d empty=%b error=%0d",
                           want.front_value, want.back_value, want.count,
                           want.is_empty, want.error);
                  $display("   actual   front=%h back=%h count=%0d empty=%b error=%0d",
                           rsp_ch.front_value, rsp_ch.back_value, rsp_ch.count,
                           rsp_ch.is_empty, rsp_ch.error);
               end
            end
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_sent = 1'b1;
         apply_operation(req_ch.kind, req_ch.value, want);
         expected_results = {expected_results, want};
         accepted_items++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.kind   = OP_QUERY;
      req_ch.value  = '0;
      rsp_ch.ready  = 1'b0;
      build_directed();
      build_random();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (accepted_items < total_items) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d operations: %0d pushes, %0d pops, %0d queries or unused kinds",
               accepted_items, push_total, pop_total, query_total);
      $display("%0d push-when-full, %0d pop-when-empty, peak occupancy %0d, %0d mismatches",
               full_errors, empty_errors, peak_count, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
